/* rtl/ufa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufa_pkg
// Shared types and constants for the UVC payload frame assembler.
// ----------------------------------------------------------------------------
package ufa_pkg;

  localparam int unsigned MaxPacketBytes = 1024;
  localparam int unsigned LenW           = 11;
  localparam int unsigned FrameW         = 16;
  localparam int unsigned ResFifoDepth   = 4;
  localparam int unsigned ResPtrW        = $clog2(ResFifoDepth);
  localparam int unsigned ResCntW        = $clog2(ResFifoDepth + 1);

  localparam logic [15:0] FrameTargetReset     = 16'd38400;
  localparam logic [15:0] AcceptThresholdReset = 16'd34560;

  // header flag bit positions
  localparam int unsigned FlagFidBit = 0;
  localparam int unsigned FlagErrBit = 6;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_COMPLETE = 2'd1,
    KIND_DROPPED  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFG_FRAME_TARGET     = 2'd0,
    CFG_ACCEPT_THRESHOLD = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]      data_byte;
    logic            packet_first;
    logic [LenW-1:0] packet_length;
  } item_t;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        byte_value;
    logic [FrameW-1:0] frame_offset;
    logic [FrameW-1:0] frame_length;
    logic              last;
  } res_t;

endpackage

/* rtl/ufa_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufa_core
// Packet/frame state and the per-byte decision logic; produces up to two
// results for the registered input byte.
// ----------------------------------------------------------------------------
module ufa_core import ufa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  input  item_t             item_i,
  input  logic              adv_i,
  output res_t              res0_o,
  output res_t              res1_o,
  output logic [1:0]        res_cnt_o
);

  logic [15:0]       target_bytes_q, accept_thr_q;
  logic [FrameW-1:0] frame_count_q, frame_count_d;
  logic              fid_valid_q, fid_valid_d;
  logic              fid_q, fid_d;
  logic [LenW-1:0]   packet_pos_q, packet_pos_d;
  logic [7:0]        hdr_len_q, hdr_len_d;
  logic              pkt_ok_q, pkt_ok_d;
  logic              discard_q, discard_d;

  logic [LenW-1:0]   pos, plen;
  logic [FrameW-1:0] tgt, fc_clip;
  logic [FrameW:0]   fc_inc;
  logic [LenW:0]     pos_inc;
  logic              fid;

  always_comb begin
    pos     = item_i.packet_first ? '0 : packet_pos_q;
    plen    = (item_i.packet_length > LenW'(MaxPacketBytes)) ? LenW'(MaxPacketBytes)
                                                           : item_i.packet_length;
    tgt     = (target_bytes_q == '0) ? FrameW'(1) : target_bytes_q;
    fid     = item_i.data_byte[FlagFidBit];
    fc_clip = (frame_count_q > tgt) ? tgt : frame_count_q;
    fc_inc  = {1'b0, frame_count_q} + (FrameW+1)'(1);
    pos_inc = {1'b0, pos} + (LenW+1)'(1);

    frame_count_d = frame_count_q;
    fid_valid_d   = fid_valid_q;
    fid_d         = fid_q;
    hdr_len_d     = hdr_len_q;
    pkt_ok_d      = pkt_ok_q;
    discard_d     = discard_q;
    res0_o        = '0;
    res1_o        = '0;
    res_cnt_o     = 2'd0;

    if (pos == '0) begin
      hdr_len_d = item_i.data_byte;
      pkt_ok_d  = 1'b0;
      discard_d = 1'b0;
    end else if (pos == LenW'(1) && !item_i.packet_first) begin
      // flags byte: validate header, close frame on frame-id toggle
      if (plen < LenW'(2) || hdr_len_q < 8'd2 || LenW'(hdr_len_q) > plen ||
          item_i.data_byte[FlagErrBit]) begin
        pkt_ok_d = 1'b0;
      end else begin
        if (fid_valid_q && fid != fid_q) begin
          if (frame_count_q >= accept_thr_q) begin
            if (fc_clip != '0) begin
              res0_o.kind         = KIND_COMPLETE;
              res0_o.frame_length = fc_clip;
              res0_o.last         = 1'b1;
              res_cnt_o           = 2'd1;
            end
            frame_count_d = '0;
          end else if (frame_count_q != '0) begin
            res0_o.kind         = KIND_DROPPED;
            res0_o.frame_length = frame_count_q;
            res0_o.last         = 1'b1;
            res_cnt_o           = 2'd1;
            frame_count_d       = '0;
          end
        end
        fid_d       = fid;
        fid_valid_d = 1'b1;
        pkt_ok_d    = 1'b1;
        discard_d   = 1'b0;
      end
    end else if (pkt_ok_q && !discard_q && pos >= LenW'(2) &&
                 pos >= LenW'(hdr_len_q) && pos < plen) begin
      res0_o.kind         = KIND_PAYLOAD;
      res0_o.byte_value   = item_i.data_byte;
      res0_o.frame_offset = frame_count_q;
      if (fc_inc >= {1'b0, tgt}) begin
        res1_o.kind         = KIND_COMPLETE;
        res1_o.frame_length = tgt;
        res1_o.last         = 1'b1;
        res_cnt_o           = 2'd2;
        frame_count_d       = '0;
        discard_d           = 1'b1;
      end else begin
        res0_o.last   = 1'b1;
        res_cnt_o     = 2'd1;
        frame_count_d = fc_inc[FrameW-1:0];
      end
    end

    // saturate at all ones
    packet_pos_d = pos_inc[LenW] ? '1 : pos_inc[LenW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_bytes_q <= FrameTargetReset;
      accept_thr_q   <= AcceptThresholdReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_TARGET:     target_bytes_q <= cfg_data_i;
        CFG_ACCEPT_THRESHOLD: accept_thr_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= '0;
      fid_valid_q   <= 1'b0;
      fid_q         <= 1'b0;
      packet_pos_q  <= '0;
      hdr_len_q     <= '0;
      pkt_ok_q      <= 1'b0;
      discard_q     <= 1'b0;
    end else if (adv_i) begin
      frame_count_q <= frame_count_d;
      fid_valid_q   <= fid_valid_d;
      fid_q         <= fid_d;
      packet_pos_q  <= packet_pos_d;
      hdr_len_q     <= hdr_len_d;
      pkt_ok_q      <= pkt_ok_d;
      discard_q     <= discard_d;
    end
  end

endmodule

/* rtl/ufa_res_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufa_res_fifo
// Small result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module ufa_res_fifo import ufa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_cnt_i,
  input  res_t       push0_i,
  input  res_t       push1_i,
  input  logic       pop_i,
  output res_t       head_o,
  output logic       valid_o,
  output logic       room_o
);

  res_t               slot_q [ResFifoDepth];
  logic [ResPtrW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nxt;
  logic [ResCntW-1:0] cnt_q;
  logic               pop;

  assign valid_o    = (cnt_q != '0);
  assign pop        = pop_i && valid_o;
  assign head_o     = slot_q[rd_ptr_q];
  // room for a full pair of results
  assign room_o     = (cnt_q <= ResCntW'(ResFifoDepth - 2));
  assign wr_ptr_nxt = wr_ptr_q + ResPtrW'(1);

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      slot_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      slot_q[wr_ptr_nxt] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + ResPtrW'(push_cnt_i);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + ResPtrW'(1);
      end
      cnt_q <= cnt_q + ResCntW'(push_cnt_i) - ResCntW'(pop);
    end
  end

endmodule

/* rtl/uvc_payload_frame_assembler_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvc_payload_frame_assembler_unit
// Parses isochronous UVC packet bytes and emits payload bytes with their
// frame offset, plus frame complete / frame dropped events.
// ----------------------------------------------------------------------------
// Takes one packet byte per cycle. A byte is registered on acceptance, decoded
// in the next cycle and its results (none, one, or a payload byte followed by
// a frame complete) go into a four-entry result queue once it has room for
// a full pair of results. The queue hands out one result per cycle while
// the result side is ready; the input stalls only while fewer than two queue
// entries are free, so with the result side always ready the input sustains
// one byte per cycle. Configuration writes are always taken and are meant to
// happen only while the block is idle.
module uvc_payload_frame_assembler_unit import ufa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  // packet bytes
  input  logic              data_valid_i,
  output logic              data_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              packet_first_i,
  input  logic [LenW-1:0]   packet_length_i,
  // results
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic [1:0]        kind_o,
  output logic [7:0]        byte_value_o,
  output logic [FrameW-1:0] frame_offset_o,
  output logic [FrameW-1:0] frame_length_o,
  output logic              last_o
);

  item_t      item_q;
  logic       item_vld_q;
  logic       adv, room;
  res_t       res0, res1, head;
  logic [1:0] res_cnt;

  assign cfg_ready_o  = 1'b1;
  assign adv          = item_vld_q && room;
  assign data_ready_o = !item_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (data_ready_o) begin
      item_vld_q <= data_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_ready_o && data_valid_i) begin
      item_q <= '{data_byte: data_byte_i, packet_first: packet_first_i,
                  packet_length: packet_length_i};
    end
  end

  ufa_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_q),
    .adv_i       (adv),
    .res0_o      (res0),
    .res1_o      (res1),
    .res_cnt_o   (res_cnt)
  );

  ufa_res_fifo u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (adv ? res_cnt : 2'd0),
    .push0_i    (res0),
    .push1_i    (res1),
    .pop_i      (res_ready_i),
    .head_o     (head),
    .valid_o    (res_valid_o),
    .room_o     (room)
  );

  assign kind_o         = head.kind;
  assign byte_value_o   = head.byte_value;
  assign frame_offset_o = head.frame_offset;
  assign frame_length_o = head.frame_length;
  assign last_o         = head.last;

endmodule

/* rtl/ufa_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufa_checker
// Port-level checks for the frame assembler, bound to the top level.
// ----------------------------------------------------------------------------
module ufa_checker import ufa_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              res_valid_o,
  input logic              res_ready_i,
  input logic [1:0]        kind_o,
  input logic [7:0]        byte_value_o,
  input logic [FrameW-1:0] frame_offset_o,
  input logic [FrameW-1:0] frame_length_o,
  input logic              last_o
);

  // a result request that is not taken stays put
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(kind_o) &&
      $stable(byte_value_o) && $stable(frame_offset_o) &&
      $stable(frame_length_o) && $stable(last_o))
    else $error("result request changed before it was taken");

  a_payload_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && kind_o == KIND_PAYLOAD |-> frame_length_o == '0)
    else $error("payload result carries a frame length");

  // frame events are always the last result of their byte and never empty
  a_event_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (kind_o == KIND_COMPLETE || kind_o == KIND_DROPPED) |->
      last_o && frame_length_o != '0 && byte_value_o == '0 &&
      frame_offset_o == '0)
    else $error("malformed frame event");

  // a payload byte that is not last is followed by its frame completion
  a_payload_then_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_ready_i && kind_o == KIND_PAYLOAD && !last_o |=>
      res_valid_o && kind_o == KIND_COMPLETE)
    else $error("payload without last not followed by frame complete");

endmodule

bind uvc_payload_frame_assembler_unit ufa_checker u_ufa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_o    (res_valid_o),
  .res_ready_i    (res_ready_i),
  .kind_o         (kind_o),
  .byte_value_o   (byte_value_o),
  .frame_offset_o (frame_offset_o),
  .frame_length_o (frame_length_o),
  .last_o         (last_o)
);
